FILE: rtl/pntf_pkg.sv
// Shared constants, codes and controller/datapath interface types for the Petri net firing block.
`default_nettype none

package pntf_pkg;

	localparam int PLACES      = 1024;
	localparam int ARCS        = 4096;
	localparam int TRANSITIONS = 1024;

	localparam int OP_W      = 3;
	localparam int IDX_W     = 12;
	localparam int TOKEN_W   = 32;
	localparam int PLACE_W   = $clog2(PLACES);
	localparam int ARC_AW    = $clog2(ARCS);
	localparam int PTR_W     = ARC_AW + 1;
	localparam int TRANS_AW  = $clog2(TRANSITIONS + 1);
	localparam int ARC_ENT_W = 1 + PLACE_W + TOKEN_W;
	localparam int TRN_ENT_W = 2 * PTR_W;
	localparam int STATUS_W  = 2;

	localparam logic [TOKEN_W-1:0] TOKEN_LIMIT = '1;

	localparam logic [OP_W-1:0] OP_WR_MARK  = 3'd0;
	localparam logic [OP_W-1:0] OP_WR_ARC   = 3'd1;
	localparam logic [OP_W-1:0] OP_WR_TRANS = 3'd2;
	localparam logic [OP_W-1:0] OP_RD_MARK  = 3'd3;
	localparam logic [OP_W-1:0] OP_FIRE     = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_EN = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVF    = 2'd2;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic wr_mark;
		logic wr_arc;
		logic wr_trans;
		logic rd_mark_idx;
		logic rd_trans_cur;
		logic rd_trans_nxt;
		logic cap_cur;
		logic cap_nxt;
		logic rd_arc;
		logic rd_arc_mark;
		logic act;
		logic advance;
		logic set_fail;
		logic result;
	} pntf_cmd_t;

	typedef struct packed {
		logic            clr_last;
		logic [OP_W-1:0] op;
		logic            fire_ok;
		logic            ptr_done;
		logic            last_phase;
		logic            fail_now;
		logic            out_free;
	} pntf_sts_t;

endpackage

`default_nettype wire

FILE: rtl/pntf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pntf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pntf_ctrl.sv
// Sequencer for load, read and fire operations of the Petri net firing block.
`default_nettype none

module pntf_ctrl
	import pntf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire pntf_sts_t sts,
	output pntf_cmd_t      cmd
);

	typedef enum logic [8:0] {
		S_CLR   = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_EXEC  = 9'b000000100,
		S_TNXT  = 9'b000001000,
		S_TCAP  = 9'b000010000,
		S_ARC   = 9'b000100000,
		S_AWAIT = 9'b001000000,
		S_MARK  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				unique case (sts.op)
					OP_WR_MARK:  cmd.wr_mark = 1'b1;
					OP_WR_ARC:   cmd.wr_arc = 1'b1;
					OP_WR_TRANS: cmd.wr_trans = 1'b1;
					OP_RD_MARK:  cmd.rd_mark_idx = 1'b1;
					OP_FIRE: begin
						if (sts.fire_ok) begin
							cmd.rd_trans_cur = 1'b1;
							state_d          = S_TNXT;
						end else begin
							cmd.set_fail = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_TNXT: begin
				cmd.cap_cur      = 1'b1;
				cmd.rd_trans_nxt = 1'b1;
				state_d          = S_TCAP;
			end
			S_TCAP: begin
				cmd.cap_nxt = 1'b1;
				state_d     = S_ARC;
			end
			S_ARC: begin
				if (sts.ptr_done) begin
					cmd.advance = 1'b1;
					if (sts.last_phase) begin
						state_d = S_DONE;
					end
				end else begin
					cmd.rd_arc = 1'b1;
					state_d    = S_AWAIT;
				end
			end
			S_AWAIT: begin
				cmd.rd_arc_mark = 1'b1;
				state_d         = S_MARK;
			end
			S_MARK: begin
				cmd.act = 1'b1;
				state_d = sts.fail_now ? S_DONE : S_ARC;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.result = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	a_fire_walk_only_for_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TNXT) |-> (sts.op == OP_FIRE))
		else $error("transition walk entered for a non-fire transaction");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result |-> $past(state_q == S_EXEC || state_q == S_ARC ||
		                     state_q == S_MARK || state_q == S_DONE))
		else $error("result issued without completed work");

	a_clear_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR && sts.clr_last) |=> (state_q == S_IDLE))
		else $error("clearing pass did not end in idle");

endmodule

`default_nettype wire

FILE: rtl/pntf_dp.sv
// Datapath: marking, arc and transition stores, arc walk pointer and result register.
`default_nettype none

module pntf_dp
	import pntf_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pntf_cmd_t           cmd,
	output pntf_sts_t                sts,
	input  wire logic [OP_W-1:0]     op,
	input  wire logic [IDX_W-1:0]    index,
	input  wire logic [PLACE_W-1:0]  arc_place,
	input  wire logic [TOKEN_W-1:0]  arc_weight,
	input  wire logic                arc_inhibits,
	input  wire logic [PTR_W-1:0]    preset_start,
	input  wire logic [PTR_W-1:0]    postset_start,
	input  wire logic                rsp_stall,
	output logic                     rsp_valid,
	output logic [STATUS_W-1:0]      status,
	output logic                     fired,
	output logic [TOKEN_W-1:0]       read_value
);

	typedef enum logic [2:0] {
		PH_CHECK   = 3'b001,
		PH_CONSUME = 3'b010,
		PH_PRODUCE = 3'b100
	} phase_t;

	// transaction registers
	logic [OP_W-1:0]    op_q;
	logic [IDX_W-1:0]   idx_q;
	logic [PLACE_W-1:0] place_q;
	logic [TOKEN_W-1:0] weight_q;
	logic               inh_q;
	logic [PTR_W-1:0]   pre_in_q;
	logic [PTR_W-1:0]   post_in_q;

	// walk state
	phase_t             phase_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [PTR_W-1:0]   pre_q;
	logic [PTR_W-1:0]   post_q;
	logic [PTR_W-1:0]   end_post_q;
	logic [TOKEN_W-1:0] arc_w_q;
	logic               arc_inh_q;
	logic [PLACE_W-1:0] arc_pl_q;
	logic               fail_q;
	logic               ovf_q;
	logic               fired_q;
	logic [PLACE_W-1:0] clr_cnt_q;

	// result register
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic                fired_out_q;
	logic [TOKEN_W-1:0]  read_value_q;

	// store ports
	logic                 mark_we, mark_re;
	logic [PLACE_W-1:0]   mark_waddr, mark_raddr;
	logic [TOKEN_W-1:0]   mark_wdata, mark_rdata;
	logic                 arc_we;
	logic [ARC_ENT_W-1:0] arc_rdata;
	logic                 trn_we, trn_re;
	logic [TRANS_AW-1:0]  trn_raddr;
	logic [TRN_ENT_W-1:0] trn_rdata;

	logic [PTR_W-1:0]   cur_end;
	logic               idx_place_ok;
	logic               less;
	logic [TOKEN_W:0]   sum;
	logic               sum_ovf;

	function automatic logic [PTR_W-1:0] clip_end(input logic [PTR_W-1:0] e);
		return (e > PTR_W'(ARCS)) ? PTR_W'(ARCS) : e;
	endfunction

	assign idx_place_ok = ({1'b0, idx_q} < (IDX_W + 1)'(PLACES));
	assign cur_end      = (phase_q == PH_PRODUCE) ? end_post_q : clip_end(post_q);
	assign less         = (mark_rdata < arc_w_q);
	assign sum          = {1'b0, mark_rdata} + {1'b0, arc_w_q};
	assign sum_ovf      = (sum >= {1'b0, TOKEN_LIMIT});

	always_comb begin
		mark_we    = 1'b0;
		mark_waddr = arc_pl_q;
		mark_wdata = '0;
		if (cmd.clr_step) begin
			mark_we    = 1'b1;
			mark_waddr = clr_cnt_q;
		end else if (cmd.wr_mark) begin
			mark_we    = idx_place_ok;
			mark_waddr = idx_q[PLACE_W-1:0];
			mark_wdata = weight_q;
		end else if (cmd.act) begin
			unique case (phase_q)
				PH_CONSUME: begin
					mark_we    = !arc_inh_q;
					mark_wdata = less ? '0 : mark_rdata - arc_w_q;
				end
				PH_PRODUCE: begin
					mark_we    = !sum_ovf;
					mark_wdata = sum[TOKEN_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign mark_re    = cmd.rd_mark_idx || cmd.rd_arc_mark;
	assign mark_raddr = cmd.rd_arc_mark ? arc_rdata[TOKEN_W +: PLACE_W] : idx_q[PLACE_W-1:0];

	assign arc_we    = cmd.wr_arc && ({1'b0, idx_q} < (IDX_W + 1)'(ARCS));
	assign trn_we    = cmd.wr_trans && ({1'b0, idx_q} <= (IDX_W + 1)'(TRANSITIONS));
	assign trn_re    = cmd.rd_trans_cur || cmd.rd_trans_nxt;
	assign trn_raddr = cmd.rd_trans_nxt ? idx_q[TRANS_AW-1:0] + TRANS_AW'(1)
	                                    : idx_q[TRANS_AW-1:0];

	pntf_ram #(.WIDTH(TOKEN_W), .DEPTH(PLACES)) u_marking (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.re    (mark_re),
		.raddr (mark_raddr),
		.rdata (mark_rdata)
	);

	pntf_ram #(.WIDTH(ARC_ENT_W), .DEPTH(ARCS)) u_arcs (
		.clk   (clk),
		.we    (arc_we),
		.waddr (idx_q[ARC_AW-1:0]),
		.wdata ({inh_q, place_q, weight_q}),
		.re    (cmd.rd_arc),
		.raddr (ptr_q[ARC_AW-1:0]),
		.rdata (arc_rdata)
	);

	pntf_ram #(.WIDTH(TRN_ENT_W), .DEPTH(TRANSITIONS + 1)) u_transitions (
		.clk   (clk),
		.we    (trn_we),
		.waddr (idx_q[TRANS_AW-1:0]),
		.wdata ({pre_in_q, post_in_q}),
		.re    (trn_re),
		.raddr (trn_raddr),
		.rdata (trn_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= op;
			idx_q     <= index;
			place_q   <= arc_place;
			weight_q  <= arc_weight;
			inh_q     <= arc_inhibits;
			pre_in_q  <= preset_start;
			post_in_q <= postset_start;
		end
		if (cmd.cap_cur) begin
			pre_q  <= trn_rdata[PTR_W +: PTR_W];
			post_q <= trn_rdata[PTR_W-1:0];
		end
		if (cmd.cap_nxt) begin
			end_post_q <= clip_end(trn_rdata[PTR_W +: PTR_W]);
		end
		if (cmd.rd_arc_mark) begin
			arc_inh_q <= arc_rdata[ARC_ENT_W-1];
			arc_pl_q  <= arc_rdata[TOKEN_W +: PLACE_W];
			arc_w_q   <= arc_rdata[TOKEN_W-1:0];
		end
		if (cmd.result) begin
			status_q     <= fail_q ? ST_NOT_EN : (ovf_q ? ST_OVF : ST_OK);
			fired_out_q  <= fired_q;
			read_value_q <= (op_q == OP_RD_MARK && idx_place_ok) ? mark_rdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CHECK;
			ptr_q       <= '0;
			fail_q      <= 1'b0;
			ovf_q       <= 1'b0;
			fired_q     <= 1'b0;
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + PLACE_W'(1);
			end
			if (cmd.load) begin
				fail_q  <= 1'b0;
				ovf_q   <= 1'b0;
				fired_q <= 1'b0;
			end
			if (cmd.set_fail) begin
				fail_q <= 1'b1;
			end
			if (cmd.cap_nxt) begin
				phase_q <= PH_CHECK;
				ptr_q   <= pre_q;
			end
			if (cmd.act) begin
				ptr_q <= ptr_q + PTR_W'(1);
				if (phase_q == PH_CHECK && (less ^ arc_inh_q)) begin
					fail_q <= 1'b1;
				end
				if (phase_q == PH_PRODUCE && sum_ovf) begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.advance) begin
				unique case (phase_q)
					PH_CHECK: begin
						phase_q <= PH_CONSUME;
						ptr_q   <= pre_q;
					end
					PH_CONSUME: begin
						phase_q <= PH_PRODUCE;
						ptr_q   <= post_q;
					end
					PH_PRODUCE: fired_q <= 1'b1;
					default: phase_q <= PH_CHECK;
				endcase
			end
			if (cmd.result) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clr_last   = (clr_cnt_q == PLACE_W'(PLACES - 1));
	assign sts.op         = op_q;
	assign sts.fire_ok    = ({1'b0, idx_q} < (IDX_W + 1)'(TRANSITIONS));
	assign sts.ptr_done   = (ptr_q >= cur_end);
	assign sts.last_phase = (phase_q == PH_PRODUCE);
	assign sts.fail_now   = (phase_q == PH_CHECK) && (less ^ arc_inh_q);
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign fired      = fired_out_q;
	assign read_value = read_value_q;

	a_arc_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_arc |-> (ptr_q < cur_end) && (ptr_q < PTR_W'(ARCS)))
		else $error("arc read outside the walked range");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result |-> (!rsp_valid_q || !rsp_stall))
		else $error("pending result overwritten");

	a_check_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act && phase_q == PH_CHECK) |-> !mark_we)
		else $error("marking written during enabledness check");

	a_fail_not_fired: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.result && fail_q) |-> !fired_q)
		else $error("failed fire reported as fired");

endmodule

`default_nettype wire

FILE: rtl/petri_net_transition_firing.sv
// Top level of the Petri net transition firing block with inhibitor arcs.
// Request channel (req_valid/req_stall) carries one operation per transaction:
// write marking, write arc, write transition pointers, read marking, or fire.
// Response channel (rsp_valid/rsp_stall) returns exactly one transaction per
// request: status, fired and read_value, in request order.
// After reset a clearing pass zeroes the marking store, one place per cycle,
// with req_stall high. Arc and transition stores are not cleared.
// Load and read operations pass the execute and done states before responding.
// Fire walks the preset arcs once to check enabledness and once to consume,
// and the postset arcs once to produce; each arc costs an arc read and a
// marking read, plus a marking write when consuming or producing, on stores
// with one write and one read port. A failing check ends the walk early.
// One operation is in flight at a time; the next request is accepted as soon
// as the finished response sits in the output register, even if rsp_stall is
// high. A stalled response holds; the block waits with a new result until the
// output register frees.
`default_nettype none

module petri_net_transition_firing
	import pntf_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire logic [OP_W-1:0]     op,
	input  wire logic [IDX_W-1:0]    index,
	input  wire logic [PLACE_W-1:0]  arc_place,
	input  wire logic [TOKEN_W-1:0]  arc_weight,
	input  wire logic                arc_inhibits,
	input  wire logic [PTR_W-1:0]    preset_start,
	input  wire logic [PTR_W-1:0]    postset_start,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic [STATUS_W-1:0]      status,
	output logic                     fired,
	output logic [TOKEN_W-1:0]       read_value
);

	pntf_cmd_t cmd;
	pntf_sts_t sts;

	pntf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	pntf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.index         (index),
		.arc_place     (arc_place),
		.arc_weight    (arc_weight),
		.arc_inhibits  (arc_inhibits),
		.preset_start  (preset_start),
		.postset_start (postset_start),
		.rsp_stall     (rsp_stall),
		.rsp_valid     (rsp_valid),
		.status        (status),
		.fired         (fired),
		.read_value    (read_value)
	);

endmodule

`default_nettype wire

FILE: sim/tb_petri_net_transition_firing.sv
// Self-checking testbench for the Petri net transition firing block.
`default_nettype none

module tb_petri_net_transition_firing;
	import pntf_pkg::*;

	localparam int REWRITE = 10000;
	localparam int REGION  = 128;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [IDX_W-1:0]   idx;
		logic [PLACE_W-1:0] place;
		logic [TOKEN_W-1:0] weight;
		logic               inh;
		logic [PTR_W-1:0]   ps;
		logic [PTR_W-1:0]   qs;
	} net_op_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                fired;
		logic [TOKEN_W-1:0]  value;
	} net_rsp_t;

	class net_scoreboard;
		logic [TOKEN_W-1:0] tokens[PLACES];
		logic [PLACE_W-1:0] a_place[ARCS];
		logic [TOKEN_W-1:0] a_weight[ARCS];
		logic               a_inh[ARCS];
		bit                 a_set[ARCS];
		int                 t_pre[TRANSITIONS+1];
		int                 t_post[TRANSITIONS+1];
		bit                 t_set[TRANSITIONS+1];
		net_rsp_t           pending[$];
		int                 errors;

		function new();
			foreach (tokens[i]) tokens[i] = '0;
			foreach (a_set[i]) a_set[i] = 0;
			foreach (t_set[i]) t_set[i] = 0;
			errors = 0;
		endfunction

		function int clip(int e);
			return (e > ARCS) ? ARCS : e;
		endfunction

		// -1 when transition t can be fired without touching unwritten entries
		function int missing(int t);
			if (!t_set[t]) return REWRITE + t;
			if (!t_set[t+1]) return REWRITE + t + 1;
			for (int i = t_pre[t]; i < clip(t_post[t]); i++)
				if (!a_set[i]) return (i < REGION) ? i : REWRITE + t;
			for (int i = t_post[t]; i < clip(t_pre[t+1]); i++)
				if (!a_set[i]) return (i < REGION) ? i : REWRITE + t + 1;
			return -1;
		endfunction

		function net_rsp_t fire(int t);
			net_rsp_t r;
			bit ok;
			logic [TOKEN_W:0] sum;
			r = '{ST_OK, 1'b0, '0};
			ok = 1;
			for (int i = t_pre[t]; i < clip(t_post[t]); i++)
				if ((tokens[a_place[i]] < a_weight[i]) != a_inh[i]) ok = 0;
			if (!ok) begin
				r.status = ST_NOT_EN;
				return r;
			end
			for (int i = t_pre[t]; i < clip(t_post[t]); i++)
				if (!a_inh[i])
					tokens[a_place[i]] = (tokens[a_place[i]] >= a_weight[i]) ?
						tokens[a_place[i]] - a_weight[i] : '0;
			for (int i = t_post[t]; i < clip(t_pre[t+1]); i++) begin
				sum = {1'b0, tokens[a_place[i]]} + {1'b0, a_weight[i]};
				if (sum >= {1'b0, TOKEN_LIMIT}) r.status = ST_OVF;
				else tokens[a_place[i]] = sum[TOKEN_W-1:0];
			end
			r.fired = 1'b1;
			return r;
		endfunction

		function void note(net_op_t x);
			net_rsp_t r;
			r = '{ST_OK, 1'b0, '0};
			case (x.op)
				OP_WR_MARK: if (x.idx < PLACES) tokens[x.idx] = x.weight;
				OP_WR_ARC: begin
					a_place[x.idx] = x.place;
					a_weight[x.idx] = x.weight;
					a_inh[x.idx] = x.inh;
					a_set[x.idx] = 1;
				end
				OP_WR_TRANS: if (x.idx <= TRANSITIONS) begin
					t_pre[x.idx] = x.ps;
					t_post[x.idx] = x.qs;
					t_set[x.idx] = 1;
				end
				OP_RD_MARK: if (x.idx < PLACES) r.value = tokens[x.idx];
				OP_FIRE: begin
					if (x.idx >= TRANSITIONS) r.status = ST_NOT_EN;
					else r = fire(x.idx);
				end
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		function void check(net_rsp_t got);
			net_rsp_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected response transaction");
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: status %0d/%0d fired %0d/%0d value %h/%h (exp/act)",
						e.status, got.status, e.fired, got.fired, e.value, got.value);
			end
		endfunction
	endclass

	logic                clk = 0;
	logic                arst_n = 0;
	logic                req_valid = 0;
	logic                req_stall;
	logic [OP_W-1:0]     op = '0;
	logic [IDX_W-1:0]    index = '0;
	logic [PLACE_W-1:0]  arc_place = '0;
	logic [TOKEN_W-1:0]  arc_weight = '0;
	logic                arc_inhibits = 0;
	logic [PTR_W-1:0]    preset_start = '0;
	logic [PTR_W-1:0]    postset_start = '0;
	logic                rsp_valid;
	logic                rsp_stall = 0;
	logic [STATUS_W-1:0] status;
	logic                fired;
	logic [TOKEN_W-1:0]  read_value;

	net_scoreboard sb = new();
	int  sent = 0;
	bit  calm = 0;
	bit  hold_req = 0;
	int  hold = 0;

	petri_net_transition_firing dut (.*);

	initial forever #4 clk = ~clk;

	initial begin
		#(8 * 1500000);
		$display("*** FAILED ***");
		$finish;
	end

	function logic [TOKEN_W-1:0] any_count();
		logic [TOKEN_W-1:0] w;
		w = $urandom;
		return (w == TOKEN_LIMIT) ? w - 1 : w;
	endfunction

	function net_op_t base_op(logic [OP_W-1:0] o, int idx);
		net_op_t x;
		x.op = o;
		x.idx = idx;
		x.place = $urandom;
		x.weight = any_count();
		x.inh = $urandom;
		x.ps = $urandom_range(0, 4096);
		x.qs = $urandom_range(0, 4096);
		return x;
	endfunction

	function net_op_t arc_op(int idx);
		net_op_t x;
		x = base_op(OP_WR_ARC, idx);
		x.place = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 15);
		if ($urandom_range(0, 7) != 0) x.weight = $urandom_range(0, 6);
		x.inh = ($urandom_range(0, 3) == 0);
		return x;
	endfunction

	function net_op_t trans_op(int idx);
		net_op_t x;
		x = base_op(OP_WR_TRANS, idx);
		case ($urandom_range(0, 7))
			0: begin x.ps = 4096; x.qs = 4096; end
			1: begin x.ps = $urandom_range(5, 120); x.qs = x.ps - $urandom_range(1, 5); end
			default: begin x.ps = $urandom_range(0, 120); x.qs = x.ps + $urandom_range(0, 4); end
		endcase
		return x;
	endfunction

	function net_op_t random_op();
		net_op_t x;
		int r, t, m;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			if ($urandom_range(0, 19) == 0) return base_op(OP_FIRE, $urandom_range(1024, 4095));
			t = $urandom_range(0, 15);
			m = sb.missing(t);
			if (m < 0) return base_op(OP_FIRE, t);
			if (m >= REWRITE) return trans_op(m - REWRITE);
			return arc_op(m);
		end
		if (r < 55)
			return arc_op(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) :
				$urandom_range(0, REGION - 1));
		if (r < 65) begin
			if ($urandom_range(0, 3) == 0) return base_op(OP_WR_TRANS, $urandom_range(20, 4095));
			return trans_op($urandom_range(0, 16));
		end
		if (r < 80) begin
			x = base_op(OP_WR_MARK, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) :
				$urandom_range(0, 15));
			case ($urandom_range(0, 9))
				0, 1: x.weight = $urandom_range(32'hFFFFFF00, 32'hFFFFFFFE);
				2: x.weight = any_count();
				default: x.weight = $urandom_range(0, 10);
			endcase
			return x;
		end
		if (r < 97)
			return base_op(OP_RD_MARK, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) :
				$urandom_range(0, 15));
		return base_op($urandom_range(5, 7), $urandom);
	endfunction

	function bit idle_now();
		return !calm && ($urandom_range(0, 99) < 35);
	endfunction

	task send(net_op_t x);
		while (idle_now()) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		op <= x.op;
		index <= x.idx;
		arc_place <= x.place;
		arc_weight <= x.weight;
		arc_inhibits <= x.inh;
		preset_start <= x.ps;
		postset_start <= x.qs;
		do @(posedge clk); while (req_stall);
		sb.note(x);
		sent++;
	endtask

	task send_arc(int idx, int pl, logic [TOKEN_W-1:0] w, bit inh);
		net_op_t x;
		x = base_op(OP_WR_ARC, idx);
		x.place = pl;
		x.weight = w;
		x.inh = inh;
		send(x);
	endtask

	task send_trans(int idx, int ps, int qs);
		net_op_t x;
		x = base_op(OP_WR_TRANS, idx);
		x.ps = ps;
		x.qs = qs;
		send(x);
	endtask

	task send_mark(int idx, logic [TOKEN_W-1:0] w);
		net_op_t x;
		x = base_op(OP_WR_MARK, idx);
		x.weight = w;
		send(x);
	endtask

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			sb.check('{status, fired, read_value});
		if (hold_req) begin
			hold_req = 0;
			hold = 300;
		end
		if (hold > 0) begin
			hold--;
			rsp_stall <= 1;
		end else begin
			rsp_stall <= idle_now();
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// small net: overflow on postset, inhibitor, repeated preset place
		send_mark(0, 5);
		send_mark(1, 32'hFFFFFFFE);
		send_mark(1023, 32'hFFFFFFFE);
		send_arc(0, 0, 2, 0);
		send_arc(1, 2, 1, 1);
		send_arc(2, 1, 1, 0);
		send_arc(3, 3, 7, 0);
		send_arc(4, 3, 3, 0);
		send_trans(0, 0, 2);
		send_trans(1, 3, 5);
		send_trans(2, 5, 5);
		send(base_op(OP_FIRE, 0));
		send(base_op(OP_RD_MARK, 0));
		send(base_op(OP_RD_MARK, 1));
		send_mark(2, 1);
		send(base_op(OP_FIRE, 0));
		send(base_op(OP_FIRE, 1));
		send_mark(3, 9);
		send(base_op(OP_FIRE, 1));
		send(base_op(OP_FIRE, 4095));
		send(base_op(5, 0));
		send(base_op(7, 4095));
		send(base_op(OP_RD_MARK, 4095));
		send_mark(2000, 123);
		send_trans(4095, 4096, 4096);
		while (sent < 900) begin
			calm = (sent >= 600 && sent < 750);
			if (sent == 300) begin
				req_valid <= 0;
				while (sb.pending.size() != 0) @(posedge clk);
			end
			if (sent == 450) hold_req = 1;
			send(random_op());
		end
		req_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/pntf_pkg.sv
rtl/pntf_ram.sv
rtl/pntf_ctrl.sv
rtl/pntf_dp.sv
rtl/petri_net_transition_firing.sv
sim/tb_petri_net_transition_firing.sv
